// ===== rtl/dll_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the doubly linked list manager.
// No dependencies; imported by every rtl module of the block.
package dll_pkg;

  localparam int NODES = 16;
  localparam int IW    = $clog2(NODES);
  localparam int LW    = $clog2(NODES + 1);
  localparam logic [LW-1:0] NIL = LW'(NODES);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_ERASE      = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_FIND       = 3'd6;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [LW-1:0]      slot;
    logic [LW-1:0]      entries;
    logic               is_empty;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [LW-1:0]      prev;
    logic [LW-1:0]      next;
  } node_t;

  typedef struct packed {
    logic               we_value;
    logic               we_prev;
    logic               we_next;
    logic [IW-1:0]      waddr;
    logic signed [31:0] wvalue;
    logic [LW-1:0]      wprev;
    logic [LW-1:0]      wnext;
    logic               ra_en;
    logic [IW-1:0]      ra_addr;
    logic               rb_en;
    logic [IW-1:0]      rb_addr;
  } mem_req_t;

endpackage

// ===== rtl/doubly_linked_list_manager.sv =====
`timescale 1ns / 1ps
// Doubly linked list manager top level: sequencer, node pool, output register.
// Push: DECODE, LINK, FETCH, RESULT; pop: POP_RD, UNLINK_A/B; clear: no LINK.
// Find, erase walk k nodes (1..16, one node memory read per cycle through the walk loop).
// One transaction in flight; next input taken the cycle after its result enters out reg.
// rst_n (sync, active low) empties the list; node storage is not cleared.
module doubly_linked_list_manager
  import dll_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  mem_req_t  mem_req;
  node_t     rd_a, rd_b;
  logic      res_valid, res_ready;
  out_item_t res;
  logic      out_valid_r;
  out_item_t out_data_r;

  dll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .mem_req   (mem_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  dll_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/dll_mem.sv =====
`timescale 1ns / 1ps
// Node pool storage: value, previous and next link arrays.
// One write port with per-field enables, two registered read ports. Uses dll_pkg.
module dll_mem
  import dll_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output node_t    rd_a,
  output node_t    rd_b
);

  logic signed [31:0] value_mem [NODES];
  logic [LW-1:0]      prev_mem  [NODES];
  logic [LW-1:0]      next_mem  [NODES];

  always_ff @(posedge clk) begin
    if (req.we_value) begin
      value_mem[req.waddr] <= req.wvalue;
    end
    if (req.we_prev) begin
      prev_mem[req.waddr] <= req.wprev;
    end
    if (req.we_next) begin
      next_mem[req.waddr] <= req.wnext;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ra_en) begin
      rd_a <= '{value: value_mem[req.ra_addr], prev: prev_mem[req.ra_addr],
                next: next_mem[req.ra_addr]};
    end
    if (req.rb_en) begin
      rd_b <= '{value: value_mem[req.rb_addr], prev: prev_mem[req.rb_addr],
                next: next_mem[req.rb_addr]};
    end
  end

endmodule

// ===== rtl/dll_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for list operations: push, pop, clear, walk with shared compare, unlink.
// Drives dll_mem through a mem_req_t bundle. Uses dll_pkg.
module dll_ctrl
  import dll_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output mem_req_t  mem_req,
  input  node_t     rd_a,
  input  node_t     rd_b,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_LINK     = 9'b000000100,
    S_POP_RD   = 9'b000001000,
    S_WALK     = 9'b000010000,
    S_UNLINK_A = 9'b000100000,
    S_UNLINK_B = 9'b001000000,
    S_FETCH    = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [NODES-1:0]   free_r, free_nxt;
  logic [LW-1:0]      head_r, head_nxt;
  logic [LW-1:0]      tail_r, tail_nxt;
  logic [LW-1:0]      count_r, count_nxt;
  logic [LW-1:0]      cur_r, cur_nxt;
  logic [LW-1:0]      steps_r, steps_nxt;
  logic [LW-1:0]      slot_r, slot_nxt;
  logic [LW-1:0]      prev_r, prev_nxt;
  logic [LW-1:0]      next_r, next_nxt;
  logic [IW-1:0]      link_r, link_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               found_r, found_nxt;

  logic [IW-1:0]      low_free;
  logic               any_free;
  logic               head_ok, tail_ok;
  logic [LW-1:0]      pop_slot;

  always_comb begin
    low_free = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        low_free = IW'(i);
      end
    end
  end

  assign any_free = |free_r;
  assign head_ok  = head_r < NIL;
  assign tail_ok  = tail_r < NIL;
  assign pop_slot = (op_r == OP_POP_FRONT) ? head_r : tail_r;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    free_nxt   = free_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    steps_nxt  = steps_r;
    slot_nxt   = slot_r;
    prev_nxt   = prev_r;
    next_nxt   = next_r;
    link_nxt   = link_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    mem_req    = '0;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.operation;
          val_nxt    = in_data.item_value;
          status_nxt = ST_DONE;
          found_nxt  = 1'b0;
          steps_nxt  = '0;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FETCH;
        case (op_r)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (!any_free) begin
              status_nxt = ST_FULL;
            end else begin
              mem_req.we_value = 1'b1;
              mem_req.we_prev  = 1'b1;
              mem_req.we_next  = 1'b1;
              mem_req.waddr    = low_free;
              mem_req.wvalue   = val_r;
              mem_req.wprev    = NIL;
              mem_req.wnext    = NIL;
              free_nxt[low_free] = 1'b0;
              count_nxt = count_r + 1'b1;
              slot_nxt  = LW'(low_free);
              if (!head_ok || !tail_ok) begin
                head_nxt = LW'(low_free);
                tail_nxt = LW'(low_free);
              end else if (op_r == OP_PUSH_FRONT) begin
                mem_req.wnext = head_r;
                link_nxt  = head_r[IW-1:0];
                head_nxt  = LW'(low_free);
                state_nxt = S_LINK;
              end else begin
                mem_req.wprev = tail_r;
                link_nxt  = tail_r[IW-1:0];
                tail_nxt  = LW'(low_free);
                state_nxt = S_LINK;
              end
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (!(pop_slot < NIL)) begin
              status_nxt = ST_EMPTY;
            end else begin
              mem_req.ra_en   = 1'b1;
              mem_req.ra_addr = pop_slot[IW-1:0];
              slot_nxt  = pop_slot;
              state_nxt = S_POP_RD;
            end
          end
          OP_ERASE, OP_FIND: begin
            if (!head_ok) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              mem_req.ra_en   = 1'b1;
              mem_req.ra_addr = head_r[IW-1:0];
              cur_nxt   = head_r;
              state_nxt = S_WALK;
            end
          end
          OP_CLEAR: begin
            free_nxt  = '1;
            head_nxt  = NIL;
            tail_nxt  = NIL;
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_LINK: begin
        mem_req.waddr = link_r;
        mem_req.wprev = slot_r;
        mem_req.wnext = slot_r;
        if (op_r == OP_PUSH_FRONT) begin
          mem_req.we_prev = 1'b1;
        end else begin
          mem_req.we_next = 1'b1;
        end
        state_nxt = S_FETCH;
      end
      S_POP_RD: begin
        prev_nxt  = rd_a.prev;
        next_nxt  = rd_a.next;
        state_nxt = S_UNLINK_A;
      end
      S_WALK: begin
        if (rd_a.value == val_r) begin
          found_nxt = 1'b1;
          slot_nxt  = cur_r;
          prev_nxt  = rd_a.prev;
          next_nxt  = rd_a.next;
          state_nxt = (op_r == OP_ERASE) ? S_UNLINK_A : S_FETCH;
        end else if (steps_r == LW'(NODES - 1) || !(rd_a.next < NIL)) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_FETCH;
        end else begin
          mem_req.ra_en   = 1'b1;
          mem_req.ra_addr = rd_a.next[IW-1:0];
          cur_nxt   = rd_a.next;
          steps_nxt = steps_r + 1'b1;
        end
      end
      S_UNLINK_A: begin
        if (prev_r < NIL) begin
          mem_req.we_next = 1'b1;
          mem_req.waddr   = prev_r[IW-1:0];
          mem_req.wnext   = next_r;
        end else begin
          head_nxt = next_r;
        end
        if (!(next_r < NIL)) begin
          tail_nxt = prev_r;
        end
        free_nxt[slot_r[IW-1:0]] = 1'b1;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        state_nxt = (next_r < NIL) ? S_UNLINK_B : S_FETCH;
      end
      S_UNLINK_B: begin
        mem_req.we_prev = 1'b1;
        mem_req.waddr   = next_r[IW-1:0];
        mem_req.wprev   = prev_r;
        state_nxt       = S_FETCH;
      end
      S_FETCH: begin
        mem_req.ra_en   = 1'b1;
        mem_req.ra_addr = head_r[IW-1:0];
        mem_req.rb_en   = 1'b1;
        mem_req.rb_addr = tail_r[IW-1:0];
        state_nxt       = S_RESULT;
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status      = status_r;
    res.found       = found_r;
    res.slot        = found_r ? slot_r : NIL;
    res.entries     = count_r;
    res.is_empty    = !head_ok;
    res.front_value = head_ok ? rd_a.value : 32'sd0;
    res.back_value  = tail_ok ? rd_b.value : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_r  <= '1;
      head_r  <= NIL;
      tail_r  <= NIL;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    cur_r    <= cur_nxt;
    steps_r  <= steps_nxt;
    slot_r   <= slot_nxt;
    prev_r   <= prev_nxt;
    next_r   <= next_nxt;
    link_r   <= link_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LW'(NODES))
    else $error("node count exceeds pool size");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) == (count_r == '0))
    else $error("head pointer and node count disagree");

  a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(~free_r) == int'(count_r))
    else $error("free map and node count disagree");

  a_res_empty: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.is_empty == (res.entries == '0)))
    else $error("empty flag inconsistent with entries");

  a_res_notfound: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_NOT_FOUND) |-> (!res.found && res.slot == NIL))
    else $error("not-found transaction reports a match");

endmodule
